// ===== rtl/qrm_pkg.sv =====
// shared constants for the quaternion to rotation matrix block
// no dependencies; used by the top level and the entry divider
package qrm_pkg;

    localparam int PART_W    = 16;  // width of one quaternion part
    localparam int PROD_W    = 32;  // width of a part times a part
    localparam int SQR_W     = 33;  // width of the squared magnitude
    localparam int NUM_W     = 36;  // signed matrix numerator
    localparam int MAG_W     = 36;  // numerator magnitude
    localparam int DEN_W     = 34;  // divisor
    localparam int N_ENTRIES = 9;

endpackage

// ===== rtl/qrm_div.sv =====
// pipelined restoring divider for one matrix entry, one quotient bit per stage
// with round to nearest, saturation and sign; uses qrm_pkg
module qrm_div #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [qrm_pkg::MAG_W-1:0]   i_mag,
    input  logic [qrm_pkg::DEN_W-1:0]   i_den,
    input  logic                        i_neg,
    output logic [OUT_FRAC_BITS+1:0]    o_entry
);

    localparam int L  = OUT_FRAC_BITS + 2;
    localparam int QW = L;
    localparam int RW = qrm_pkg::DEN_W + 1;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam logic [OUT_FRAC_BITS:0] LIM = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;

    logic [RW-1:0]             r_rem [L];
    logic [qrm_pkg::DEN_W-1:0] r_den [L];
    logic                      r_neg [L];
    logic                      r_sat [L];
    logic [QW-1:0]             r_q   [L];

    for (genvar j = 0; j < L; j++) begin : g_stage
        logic [RW-1:0]             s_rem;
        logic [qrm_pkg::DEN_W-1:0] s_den;
        logic                      s_neg;
        logic                      s_sat;
        logic [QW-1:0]             s_q;
        logic                      ge;
        logic [RW-1:0]             diff;

        if (j == 0) begin : g_first
            assign s_rem = RW'(i_mag);
            assign s_den = i_den;
            assign s_neg = i_neg;
            assign s_sat = i_mag > qrm_pkg::MAG_W'(i_den);
            assign s_q   = '0;
        end else begin : g_next
            assign s_rem = r_rem[j-1];
            assign s_den = r_den[j-1];
            assign s_neg = r_neg[j-1];
            assign s_sat = r_sat[j-1];
            assign s_q   = r_q[j-1];
        end

        assign ge   = s_rem >= RW'(s_den);
        assign diff = ge ? (s_rem - RW'(s_den)) : s_rem;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= (j == L - 1) ? diff : (diff << 1);
                r_den[j] <= s_den;
                r_neg[j] <= s_neg;
                r_sat[j] <= s_sat;
                r_q[j]   <= {s_q[QW-2:0], ge};
            end
        end
    end

    // q = (t + 1) / 2 gives round to nearest, ties away from zero
    logic [QW:0]              t_inc;
    logic [OUT_FRAC_BITS:0]   q_rnd;
    logic [OUT_FRAC_BITS:0]   q_mag;

    assign t_inc   = (QW+1)'(r_q[L-1]) + (QW+1)'(1);
    assign q_rnd   = t_inc[OUT_FRAC_BITS+1:1];
    assign q_mag   = (r_sat[L-1] || q_rnd > LIM) ? LIM : q_rnd;
    assign o_entry = r_neg[L-1] ? (OW'(0) - OW'(q_mag)) : OW'(q_mag);

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// quaternion to 3x3 rotation matrix, top level
// depends on qrm_pkg and qrm_div
//
// Takes one quaternion word per cycle (w, x, y, z, signed, IN_FRAC_BITS
// fraction bits) and gives the nine entries of the active rotation matrix,
// signed with OUT_FRAC_BITS fraction bits, rounded to nearest (ties away from
// zero) and saturated to +-1. A non-unit quaternion is normalized by dividing
// through its squared magnitude; a zero quaternion gives the identity and sets
// tuser. Throughput is one word per clock while the output is not stalled. The
// pipe registers are, in order: input register, products, sums, divisor select,
// OUT_FRAC_BITS + 2 divider stages (one quotient bit each, nine dividers side by
// side) and the output register. The whole pipe advances whenever the output
// register is empty or being taken, and s_axis_tready is high exactly then.
module quaternion_to_rotation_matrix #(
    parameter int IN_FRAC_BITS  = 14,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // quat_real [15:0], quat_i [31:16], quat_j [47:32], quat_k [63:48]
    input  logic [4*qrm_pkg::PART_W-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0 .. m_row2_col2,
    // each OUT_FRAC_BITS+2 bits from the lowest up, zero filled to bytes
    output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // zero_input
    output logic m_axis_tuser
);

    localparam int OW  = OUT_FRAC_BITS + 2;
    localparam int TDW = ((9 * OW + 7) / 8) * 8;
    localparam int L   = OUT_FRAC_BITS + 2;
    localparam int NW  = qrm_pkg::NUM_W;
    localparam int PW  = qrm_pkg::PART_W;
    localparam logic [63:0] ONE_IN = 64'd1 << (2 * IN_FRAC_BITS);
    localparam logic [63:0] TOL    = ONE_IN / 64'd10000000000;
    localparam logic signed [OW-1:0] ONE_OUT = OW'(1) << OUT_FRAC_BITS;

    // the whole pipe moves together
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: input register
    logic signed [PW-1:0] r_w, r_x, r_y, r_z;
    logic                 r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= s_axis_tdata[PW-1:0];
            r_x <= s_axis_tdata[2*PW-1:PW];
            r_y <= s_axis_tdata[3*PW-1:2*PW];
            r_z <= s_axis_tdata[4*PW-1:3*PW];
        end
    end

    // stage 2: the ten products
    logic signed [qrm_pkg::PROD_W-1:0] r_ww, r_xx, r_yy, r_zz;
    logic signed [qrm_pkg::PROD_W-1:0] r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    logic                              r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xy <= r_x * r_y;
            r_zw <= r_z * r_w;
            r_xz <= r_x * r_z;
            r_yw <= r_y * r_w;
            r_yz <= r_y * r_z;
            r_xw <= r_x * r_w;
        end
    end

    // stage 3: squared magnitude and the nine numerators
    logic [qrm_pkg::SQR_W-1:0] r_m2;
    logic signed [NW-1:0]      r_n [qrm_pkg::N_ENTRIES];
    logic                      r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2 <= qrm_pkg::SQR_W'($unsigned(r_ww)) + qrm_pkg::SQR_W'($unsigned(r_xx))
                  + qrm_pkg::SQR_W'($unsigned(r_yy)) + qrm_pkg::SQR_W'($unsigned(r_zz));
            r_n[0] <= NW'(r_ww) + NW'(r_xx) - NW'(r_yy) - NW'(r_zz);
            r_n[1] <= (NW'(r_xy) - NW'(r_zw)) <<< 1;
            r_n[2] <= (NW'(r_xz) + NW'(r_yw)) <<< 1;
            r_n[3] <= (NW'(r_xy) + NW'(r_zw)) <<< 1;
            r_n[4] <= NW'(r_ww) - NW'(r_xx) + NW'(r_yy) - NW'(r_zz);
            r_n[5] <= (NW'(r_yz) - NW'(r_xw)) <<< 1;
            r_n[6] <= (NW'(r_xz) - NW'(r_yw)) <<< 1;
            r_n[7] <= (NW'(r_yz) + NW'(r_xw)) <<< 1;
            r_n[8] <= NW'(r_ww) - NW'(r_xx) - NW'(r_yy) + NW'(r_zz);
        end
    end

    // stage 4: divisor, near-unit correction, sign and magnitude
    logic [63:0]                m2_wide;
    logic                       near_one;
    logic signed [NW-1:0]       dev;
    logic [qrm_pkg::DEN_W-1:0]  den_c;
    logic signed [NW-1:0]       n_adj [qrm_pkg::N_ENTRIES];

    assign m2_wide  = 64'(r_m2);
    assign near_one = (m2_wide + TOL >= ONE_IN) && (m2_wide <= ONE_IN + TOL);
    // only used near one, where the truncated constant is exact
    assign dev      = NW'(r_m2) - NW'(ONE_IN);
    // near one the divisor is exactly one, i.e. m2 minus the deviation
    assign den_c    = near_one ? qrm_pkg::DEN_W'(NW'(r_m2) - dev)
                               : qrm_pkg::DEN_W'(r_m2);

    always_comb begin
        for (int e = 0; e < qrm_pkg::N_ENTRIES; e++) begin
            if (near_one && (e == 0 || e == 4 || e == 8)) begin
                n_adj[e] = r_n[e] + dev;
            end else begin
                n_adj[e] = r_n[e];
            end
        end
    end

    logic [qrm_pkg::MAG_W-1:0] r_mag [qrm_pkg::N_ENTRIES];
    logic                      r_neg [qrm_pkg::N_ENTRIES];
    logic [qrm_pkg::DEN_W-1:0] r_den;
    logic                      r_z4;
    logic                      r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= den_c;
            r_z4  <= (r_m2 == '0);
            for (int e = 0; e < qrm_pkg::N_ENTRIES; e++) begin
                r_neg[e] <= n_adj[e][NW-1];
                r_mag[e] <= n_adj[e][NW-1] ? qrm_pkg::MAG_W'(-n_adj[e])
                                           : qrm_pkg::MAG_W'(n_adj[e]);
            end
        end
    end

    // divider stages, one per quotient bit
    logic [OW-1:0] entry [qrm_pkg::N_ENTRIES];

    for (genvar e = 0; e < qrm_pkg::N_ENTRIES; e++) begin : g_div
        qrm_div #(
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_mag   (r_mag[e]),
            .i_den   (r_den),
            .i_neg   (r_neg[e]),
            .o_entry (entry[e])
        );
    end

    // valid and zero flag travel beside the divider
    logic r_vd [L];
    logic r_zd [L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < L; j++) begin
                r_vd[j] <= 1'b0;
            end
        end else if (en) begin
            r_vd[0] <= r_v4;
            for (int j = 1; j < L; j++) begin
                r_vd[j] <= r_vd[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zd[0] <= r_z4;
            for (int j = 1; j < L; j++) begin
                r_zd[j] <= r_zd[j-1];
            end
        end
    end

    // output register; a zero quaternion gives the identity
    logic [TDW-1:0] out_c;

    always_comb begin
        out_c = '0;
        for (int e = 0; e < qrm_pkg::N_ENTRIES; e++) begin
            if (r_zd[L-1]) begin
                out_c[e*OW +: OW] = (e == 0 || e == 4 || e == 8) ? ONE_OUT : '0;
            end else begin
                out_c[e*OW +: OW] = entry[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= r_vd[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= out_c;
            m_axis_tuser <= r_zd[L-1];
        end
    end

    // checks
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v1)
        else $error("accepted word did not enter the pipe");

    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            $signed(m_axis_tdata[OW-1:0]) == ONE_OUT && m_axis_tdata[2*OW-1:OW] == '0)
        else $error("zero quaternion without identity");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[OW-1:0]) <= ONE_OUT &&
            $signed(m_axis_tdata[OW-1:0]) >= -ONE_OUT)
        else $error("matrix entry beyond unit range");

endmodule

// ===== tb/quaternion_to_rotation_matrix_tb.sv =====
// self-checking testbench for quaternion_to_rotation_matrix
// depends on qrm_pkg and the block's rtl; predicts each matrix word and checks the output stream
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_tb;

    localparam int IN_FB   = 14;
    localparam int OUT_FB  = 16;
    localparam int ENT_W   = OUT_FB + 2;
    localparam int OUT_DW  = ((9 * ENT_W + 7) / 8) * 8;
    localparam int N_RAND  = 600;
    localparam int LATENCY = OUT_FB + 7;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [ENT_W-1:0] ent8, ent7, ent6, ent5, ent4, ent3, ent2, ent1, ent0;
        logic             is_zero;
    } t_matrix;

    // expected matrices in order, checked against each output word
    class matrix_board;
        t_matrix pending[$];
        int      n_err;

        // round(n * 2^OUT_FB / d), ties away from zero, clamped to +-1
        static function longint div_round(longint n, longint d);
            longint mag, q, lim;
            lim = longint'(1) << OUT_FB;
            mag = (n < 0) ? -n : n;
            q   = ((mag << (OUT_FB + 1)) + d) / (2 * d);
            if (q > lim) q = lim;
            return (n < 0) ? -q : q;
        endfunction

        function void note_quat(logic [63:0] q);
            longint w, x, y, z, ww, xx, yy, zz, m2, unit, dev, den;
            longint num[9];
            logic [ENT_W-1:0] e[9];
            t_matrix m;
            w = longint'($signed(q[15:0]));  x = longint'($signed(q[31:16]));
            y = longint'($signed(q[47:32])); z = longint'($signed(q[63:48]));
            ww = w*w; xx = x*x; yy = y*y; zz = z*z;
            m2 = ww + xx + yy + zz;
            unit = longint'(1) << (2 * IN_FB);
            if (m2 == 0) begin
                for (int i = 0; i < 9; i++)
                    e[i] = (i % 4 == 0) ? ENT_W'(longint'(1) << OUT_FB) : '0;
                m.is_zero = 1'b1;
            end else begin
                num[0] = ww + xx - yy - zz;  num[1] = 2*(x*y - z*w);
                num[2] = 2*(x*z + y*w);      num[3] = 2*(x*y + z*w);
                num[4] = ww - xx + yy - zz;  num[5] = 2*(y*z - x*w);
                num[6] = 2*(x*z - y*w);      num[7] = 2*(y*z + x*w);
                num[8] = ww - xx - yy + zz;
                // near-unit tolerance is zero at these widths: an exact unit magnitude divides by the unit
                dev = m2 - unit;
                den = m2;
                if (dev == 0) den = unit;
                for (int i = 0; i < 9; i++) e[i] = ENT_W'(div_round(num[i], den));
                m.is_zero = 1'b0;
            end
            m.ent0 = e[0]; m.ent1 = e[1]; m.ent2 = e[2]; m.ent3 = e[3]; m.ent4 = e[4];
            m.ent5 = e[5]; m.ent6 = e[6]; m.ent7 = e[7]; m.ent8 = e[8];
            pending.push_back(m);
        endfunction

        function void check_matrix(logic [OUT_DW-1:0] d, logic zflag);
            t_matrix exp_m;
            logic [ENT_W-1:0] got, want;
            logic [ENT_W*9-1:0] exp_flat;
            if (pending.size() == 0) begin
                $error("matrix word with no quaternion pending");
                n_err++;
                return;
            end
            exp_m = pending.pop_front();
            exp_flat = {exp_m.ent8, exp_m.ent7, exp_m.ent6, exp_m.ent5, exp_m.ent4,
                        exp_m.ent3, exp_m.ent2, exp_m.ent1, exp_m.ent0};
            for (int i = 0; i < 9; i++) begin
                got  = d[i*ENT_W +: ENT_W];
                want = exp_flat[i*ENT_W +: ENT_W];
                if (got !== want) begin
                    $error("m_row%0d_col%0d exp %0d got %0d", i / 3, i % 3,
                           $signed(want), $signed(got));
                    n_err++;
                end
            end
            if (zflag !== exp_m.is_zero) begin
                $error("zero_input exp %0b got %0b", exp_m.is_zero, zflag);
                n_err++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;   // quat_real, quat_i, quat_j, quat_k
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;        // m_row0_col0 .. m_row2_col2
    logic              m_axis_tuser;        // zero_input

    matrix_board board = new();
    bit          hold_off  = 1'b0;
    longint      cycles    = 0;

    always #5 i_clk = ~i_clk;

    quaternion_to_rotation_matrix #(.IN_FRAC_BITS(IN_FB), .OUT_FRAC_BITS(OUT_FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // mostly short gaps, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one quaternion word and wait until it is taken
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_quat({z, y, x, w});
    endtask

    // random quaternion: full range, near unit, or small parts
    task automatic send_random(bit no_gap);
        logic [15:0] p[4];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) begin
            if (kind < 4)      p[i] = 16'($urandom);
            else if (kind < 8) p[i] = 16'($signed($urandom_range(0, 16384)) -
                                          (($urandom & 1) ? 0 : 16384)) >>> 1;
            else               p[i] = 16'($signed($urandom_range(0, 6)) - 3);
        end
        send_quat(p[0], p[1], p[2], p[3], no_gap);
    endtask

    // output side: check each word, random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_matrix(m_axis_tdata, m_axis_tuser);
    end

    initial begin : sink
        int g;
        @(posedge i_rst_n);
        while (1) begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[quaternion_to_rotation_matrix] ERROR");
            $finish;
        end
    end

    initial begin : stim
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero quaternion, identity, exact unit axes, extremes
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000, 0);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000, 0);
        send_quat(16'hC000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000, 0);
        send_quat(16'h2000, 16'hE000, 16'h2000, 16'hE000, 0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 0);
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
        send_quat(16'h0001, 16'h0002, 16'h0000, 16'h0000, 0);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 0);
        send_quat(16'h4001, 16'h0000, 16'h0000, 16'h0000, 0);
        send_quat(16'h3FFF, 16'h0000, 16'h0000, 16'h0000, 0);
        // random words, with a back-to-back burst against a long receiver hold-off
        for (int n = 0; n < N_RAND; n++) begin
            if (n == 200) hold_off = 1'b1;
            send_random(n >= 200 && n < 260);
        end
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (board.pending.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.n_err == 0 && board.pending.size() == 0) begin
            $display("[quaternion_to_rotation_matrix] OK");
        end else begin
            if (board.pending.size() != 0)
                $error("%0d matrix words never arrived", board.pending.size());
            $display("[quaternion_to_rotation_matrix] ERROR");
        end
        $finish;
    end

endmodule
